>>> hdl/alabd_pkg.sv
// ----------------------------------------------------------------------------
// alabd_pkg: shared constants for the audio level / AGC / beat detector
// Register indexes, field widths and serial-unit sizing.
// ----------------------------------------------------------------------------
package alabd_pkg;

	localparam int SAMPLE_BITS_DEF   = 12;
	localparam int FRACTION_BITS_DEF = 8;

	// Configuration port
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [CFG_IDX_BITS-1:0] REG_SQUELCH = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MARGIN  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_TARGET  = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_HOLDOFF = 2'd3;

	localparam int CFG8_BITS    = 8;
	localparam int HOLDOFF_BITS = 16;
	localparam int TIME_BITS    = 32;

	localparam logic [CFG8_BITS-1:0]    SQUELCH_RST = 8'd7;
	localparam logic [CFG8_BITS-1:0]    MARGIN_RST  = 8'd11;
	localparam logic [CFG8_BITS-1:0]    TARGET_RST  = 8'd60;
	localparam logic [HOLDOFF_BITS-1:0] HOLDOFF_RST = 16'd50;

	// 31/32 averaging: x*32 - x, then shift by five
	localparam int AVG_SHIFT = 5;

	// Gain and scaled output
	localparam int GAIN_BITS    = 8;
	localparam int SCALED_BITS  = 8;
	localparam logic [SCALED_BITS-1:0] SAT_MAX = 8'd255;
	localparam int DIV_CNT_BITS = $clog2(GAIN_BITS);

	// Multiplier consumes the gain two bits per cycle
	localparam int DIGIT_BITS    = 2;
	localparam int MUL_STEPS     = GAIN_BITS / DIGIT_BITS;
	localparam int MUL_CNT_BITS  = $clog2(MUL_STEPS);

endpackage

>>> hdl/alabd_div.sv
// ----------------------------------------------------------------------------
// alabd_div: serial gain divider
// Restoring division, one quotient bit per cycle, MSB first:
// quotient = (target << FRACTION_BITS) / divisor, for divisor >= 1.0.
// ----------------------------------------------------------------------------
module alabd_div
	import alabd_pkg::*;
#(
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [GAIN_BITS-1:0]                 target,
	input  logic [SAMPLE_BITS+FRACTION_BITS-1:0] divisor,
	output logic                                 done,
	output logic [GAIN_BITS-1:0]                 quotient
);

	localparam int W  = SAMPLE_BITS + FRACTION_BITS;
	localparam int NW = GAIN_BITS + FRACTION_BITS;  // dividend width
	localparam int DW = W + GAIN_BITS - 1;          // divisor shifted to the top quotient bit
	localparam logic [DIV_CNT_BITS-1:0] LAST = DIV_CNT_BITS'(GAIN_BITS - 1);

	logic [NW-1:0]           rem_q;
	logic [DW-1:0]           dsr_q;
	logic [GAIN_BITS-1:0]    quo_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic                    busy_q;
	logic                    done_q;

	logic [DW-1:0] rem_ext;
	logic [DW-1:0] diff;
	logic          ge;

	always_comb begin
		rem_ext = DW'(rem_q);
		ge      = (rem_ext >= dsr_q);
		diff    = rem_ext - dsr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dsr_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= {target, {FRACTION_BITS{1'b0}}};
				dsr_q  <= {divisor, {(GAIN_BITS-1){1'b0}}};
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (ge) begin
					rem_q <= diff[NW-1:0];
				end
				quo_q <= {quo_q[GAIN_BITS-2:0], ge};
				dsr_q <= dsr_q >> 1;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> hdl/alabd_mul.sv
// ----------------------------------------------------------------------------
// alabd_mul: digit-serial level x gain multiplier
// Shift-add over the gain, two bits per cycle, MSB first.
// ----------------------------------------------------------------------------
module alabd_mul
	import alabd_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [SAMPLE_BITS-1:0]         multiplicand,
	input  logic [GAIN_BITS-1:0]           multiplier,
	output logic                           done,
	output logic [SAMPLE_BITS+GAIN_BITS-1:0] product
);

	localparam int PW = SAMPLE_BITS + GAIN_BITS;
	localparam logic [MUL_CNT_BITS-1:0] LAST = MUL_CNT_BITS'(MUL_STEPS - 1);

	logic [SAMPLE_BITS-1:0]  mcand_q;
	logic [GAIN_BITS-1:0]    mplier_q;
	logic [PW-1:0]           acc_q;
	logic [MUL_CNT_BITS-1:0] cnt_q;
	logic                    busy_q;
	logic                    done_q;

	logic [DIGIT_BITS-1:0]             digit;
	logic [SAMPLE_BITS+DIGIT_BITS-1:0] partial;
	logic [PW-1:0]                     acc_next;

	always_comb begin
		digit    = mplier_q[GAIN_BITS-1 -: DIGIT_BITS];
		partial  = (SAMPLE_BITS+DIGIT_BITS)'(mcand_q) * (SAMPLE_BITS+DIGIT_BITS)'(digit);
		acc_next = (acc_q << DIGIT_BITS) + PW'(partial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcand_q  <= '0;
			mplier_q <= '0;
			acc_q    <= '0;
			cnt_q    <= '0;
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				mcand_q  <= multiplicand;
				mplier_q <= multiplier;
				acc_q    <= '0;
				cnt_q    <= '0;
				busy_q   <= 1'b1;
			end else if (busy_q) begin
				acc_q    <= acc_next;
				mplier_q <= mplier_q << DIGIT_BITS;
				cnt_q    <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

>>> hdl/audio_level_agc_beat_detect_top.sv
// ----------------------------------------------------------------------------
// audio_level_agc_beat_detect_top: audio envelope, AGC and beat detector
// Per microphone sample: DC removal, squelched rectified level, long-term
// average, beat pulse with holdoff, and an auto-gain scaled level.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream (s_*): one transfer per converter sample with its
//    millisecond timestamp. Output stream (m_*): one transfer per sample.
//  - Config port: cfg_wr_en writes cfg_data into the register at cfg_index
//    (0 squelch, 1 peak margin, 2 target level, 3 holdoff ms). Write only
//    while the block is idle.
//  - Timing: a sample is worked through a sequencer: DC track, level,
//    average, beat compare (each in its own state), then the gain divider
//    (one quotient bit a cycle) and the level x gain multiplier (two gain
//    bits a cycle). The result is presented once the multiplier finishes,
//    and only then does the sequencer return to idle to take the next
//    sample, so a new sample is not accepted while one is being worked.
//  - Output stall: the result sits in an output register, so the next
//    sample is accepted while it waits. A finished result that finds the
//    register still full holds the sequencer until m_tready.
//  - Reset: clears the averages, level and last beat time to zero and loads
//    the register defaults (7, 11, 60, 50 ms). No clearing pass is needed.
// ----------------------------------------------------------------------------
module audio_level_agc_beat_detect_top
	import alabd_pkg::*;
#(
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF,
	localparam int IN_BITS  = SAMPLE_BITS + TIME_BITS,
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS = 2 * SAMPLE_BITS + SCALED_BITS + 1,
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// config write port
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	// sample stream in
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [IN_W-1:0]          s_tdata,   // mic_sample, now_ms
	// result stream out
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_W-1:0]         m_tdata    // level, average_level, scaled_level, beat
);

	localparam int W  = SAMPLE_BITS + FRACTION_BITS;  // Q(S).(F) word
	localparam int AW = W + AVG_SHIFT;                // 31/32 average intermediate
	localparam int PW = SAMPLE_BITS + GAIN_BITS;      // level x gain product

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DC,
		ST_LVL,
		ST_AVG,
		ST_BEAT,
		ST_DIV,
		ST_MUL,
		ST_DONE
	} state_t;

	state_t state_q;

	// config registers
	logic [CFG8_BITS-1:0]    squelch_q;
	logic [CFG8_BITS-1:0]    margin_q;
	logic [CFG8_BITS-1:0]    target_q;
	logic [HOLDOFF_BITS-1:0] holdoff_q;

	// captured sample
	logic [SAMPLE_BITS-1:0] mic_q;
	logic [TIME_BITS-1:0]   now_q;

	// tracker state
	logic [W-1:0]           dc_q;
	logic [SAMPLE_BITS-1:0] lvl_q;
	logic [W-1:0]           la_q;
	logic [TIME_BITS-1:0]   last_q;
	logic                   beat_q;

	// output register
	logic                   out_valid_q;
	logic [OUT_W-1:0]       out_data_q;

	// serial units
	logic                   div_start;
	logic                   div_done;
	logic [GAIN_BITS-1:0]   quotient;
	logic                   mul_start;
	logic                   mul_done;
	logic [PW-1:0]          product;

	logic [W-1:0]             mic_fix;
	logic [W-1:0]             lvl_fix;
	logic [W-1:0]             dc_next;
	logic [W-1:0]             la_next;
	logic [W-1:0]             dc_diff;
	logic [SAMPLE_BITS-1:0]   mag;
	logic [SAMPLE_BITS:0]     lvl_sum;
	logic [SAMPLE_BITS-1:0]   lvl_next;
	logic [W:0]               beat_rhs;
	logic                     over_avg;
	logic [TIME_BITS-1:0]     elapsed;
	logic                     holdoff_ok;
	logic                     small_avg;
	logic [GAIN_BITS-1:0]     gain;
	logic [SCALED_BITS-1:0]   scaled;
	logic                     out_free;
	logic                     out_load;
	logic [OUT_W-1:0]         out_word;

	// (old*31 + x) / 32, truncated
	function automatic logic [W-1:0] avg32(input logic [W-1:0] old, input logic [W-1:0] x);
		logic [AW-1:0] s;
		s = {old, {AVG_SHIFT{1'b0}}} - AW'(old) + AW'(x);
		return s[AW-1:AVG_SHIFT];
	endfunction

	always_comb begin
		mic_fix = {mic_q, {FRACTION_BITS{1'b0}}};
		lvl_fix = {lvl_q, {FRACTION_BITS{1'b0}}};
		dc_next = avg32(dc_q, mic_fix);
		la_next = avg32(la_q, lvl_fix);

		// rectify around the DC level; the shift truncates toward zero
		dc_diff  = (mic_fix >= dc_q) ? (mic_fix - dc_q) : (dc_q - mic_fix);
		mag      = dc_diff[W-1:FRACTION_BITS];
		lvl_sum  = {1'b0, lvl_q} + {1'b0, mag};
		lvl_next = (mag <= SAMPLE_BITS'(squelch_q)) ? '0 : lvl_sum[SAMPLE_BITS:1];

		// beat: level above average plus margin, and holdoff expired (wrap-safe)
		beat_rhs   = {1'b0, la_q} + (W+1)'({margin_q, {FRACTION_BITS{1'b0}}});
		over_avg   = ({1'b0, lvl_fix} > beat_rhs);
		elapsed    = now_q - last_q;
		holdoff_ok = (elapsed > TIME_BITS'(holdoff_q));

		// average below 1.0 takes the target as gain
		small_avg = (la_q[W-1:FRACTION_BITS] == '0);
		gain      = small_avg ? target_q : quotient;

		scaled   = (product > PW'(SAT_MAX)) ? SAT_MAX : product[SCALED_BITS-1:0];
		out_word = OUT_W'({beat_q, scaled, la_q[W-1:FRACTION_BITS], lvl_q});
		out_free = !out_valid_q || m_tready;
		// finished result moves into the output register once it has room
		out_load = out_free && (((state_q == ST_MUL) && mul_done) || (state_q == ST_DONE));

		div_start = (state_q == ST_BEAT);
		mul_start = (state_q == ST_DIV) && div_done;
	end

	alabd_div #(
		.SAMPLE_BITS  (SAMPLE_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.target  (target_q),
		.divisor (la_q),
		.done    (div_done),
		.quotient(quotient)
	);

	alabd_mul #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_mul (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (mul_start),
		.multiplicand(lvl_q),
		.multiplier  (gain),
		.done        (mul_done),
		.product     (product)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			squelch_q   <= SQUELCH_RST;
			margin_q    <= MARGIN_RST;
			target_q    <= TARGET_RST;
			holdoff_q   <= HOLDOFF_RST;
			mic_q       <= '0;
			now_q       <= '0;
			dc_q        <= '0;
			lvl_q       <= '0;
			la_q        <= '0;
			last_q      <= '0;
			beat_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_SQUELCH: squelch_q <= cfg_data[CFG8_BITS-1:0];
					REG_MARGIN:  margin_q  <= cfg_data[CFG8_BITS-1:0];
					REG_TARGET:  target_q  <= cfg_data[CFG8_BITS-1:0];
					REG_HOLDOFF: holdoff_q <= cfg_data[HOLDOFF_BITS-1:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_data_q  <= out_word;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						mic_q   <= s_tdata[SAMPLE_BITS-1:0];
						now_q   <= s_tdata[SAMPLE_BITS +: TIME_BITS];
						state_q <= ST_DC;
					end
				end
				ST_DC: begin
					dc_q    <= dc_next;
					state_q <= ST_LVL;
				end
				ST_LVL: begin
					lvl_q   <= lvl_next;
					state_q <= ST_AVG;
				end
				ST_AVG: begin
					la_q    <= la_next;
					state_q <= ST_BEAT;
				end
				ST_BEAT: begin
					beat_q <= over_avg && holdoff_ok;
					if (over_avg && holdoff_ok) begin
						last_q <= now_q;
					end
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
